// ===== src/wildcard_byte_pattern_scanner_assert.svh =====
// Assertion macros for the wildcard byte pattern scanner.
// Expects signals named clock and reset in the including scope.
`ifndef WILDCARD_BYTE_PATTERN_SCANNER_ASSERT_SVH
`define WILDCARD_BYTE_PATTERN_SCANNER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define WBPS_ASSERT_IMPLIES(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("wbps assertion failed: same-cycle implication");

// Next-cycle implication, checked outside reset.
`define WBPS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("wbps assertion failed: next-cycle implication");

`endif

// ===== src/wbps_pkg.sv =====
// Shared types, constants and helper functions of the wildcard byte pattern scanner.
// Used by wbps_cell, wbps_out_buf and wildcard_byte_pattern_scanner; no dependencies.
`default_nettype none
package wbps_pkg;

   localparam int MAX_PATTERN_LEN = 16;
   localparam int COUNT_WIDTH     = 32;
   localparam int NUM_CELLS       = MAX_PATTERN_LEN - 1;
   localparam int LEN_W           = 5;
   localparam int ADDR_W          = 48;
   localparam int CSR_INDEX_W     = 3;
   localparam int CSR_DATA_W      = 64;

   typedef logic [CSR_INDEX_W-1:0] csr_index_type;

   localparam csr_index_type CSR_PATTERN_LOW  = 3'd0;
   localparam csr_index_type CSR_PATTERN_HIGH = 3'd1;
   localparam csr_index_type CSR_WILDCARD     = 3'd2;
   localparam csr_index_type CSR_LENGTH       = 3'd3;
   localparam csr_index_type CSR_BASE         = 3'd4;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic              found;
      logic [ADDR_W-1:0] match_address;
   } rsp_type;

   // What one window position is compared against.
   typedef struct packed {
      logic       in_use;
      logic       wild;
      logic [7:0] pattern;
   } lane_cfg_type;

   function automatic logic [7:0] pattern_byte(input logic [63:0]      low,
                                               input logic [63:0]      high,
                                               input logic [LEN_W-1:0] k);
      logic [7:0] result;
      result = 8'h00;
      if (k < LEN_W'(8)) begin
         result = low[{k[2:0], 3'b000} +: 8];
      end else if (k < LEN_W'(16)) begin
         result = high[{k[2:0], 3'b000} +: 8];
      end
      return result;
   endfunction

   function automatic logic pattern_wild(input logic [15:0]      mask,
                                         input logic [LEN_W-1:0] k);
      logic result;
      result = 1'b0;
      if (k < LEN_W'(16)) begin
         result = mask[k[3:0]];
      end
      return result;
   endfunction

   function automatic logic lane_ok(input lane_cfg_type lane, input logic [7:0] data);
      return !lane.in_use || lane.wild || (data == lane.pattern);
   endfunction

endpackage
`default_nettype wire

// ===== src/wbps_cell.sv =====
// One window cell: holds a previous byte, passes it to the next cell, checks it.
// Depends on wbps_pkg.
`default_nettype none
module wbps_cell (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  shift_en,
   input  wire logic                  clear,
   input  wire logic [7:0]            prev_byte,
   input  wire wbps_pkg::lane_cfg_type lane,
   output logic [7:0]                 byte_out,
   output logic                       ok
);

   logic [7:0] byte_ff;
   logic [7:0] byte_in;

   always_comb begin
      byte_in = byte_ff;
      if (clear) begin
         byte_in = 8'h00;
      end else if (shift_en) begin
         byte_in = prev_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_ff <= 8'h00;
      end else begin
         byte_ff <= byte_in;
      end
   end

   assign byte_out = byte_ff;
   assign ok       = wbps_pkg::lane_ok(lane, byte_ff);

endmodule
`default_nettype wire

// ===== src/wbps_out_buf.sv =====
// Result output register with a skid entry behind it.
// Depends on wbps_pkg.
`default_nettype none
module wbps_out_buf (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire wbps_pkg::rsp_type push_data,
   input  wire logic              rsp_stall,
   output logic                   rsp_valid,
   output wbps_pkg::rsp_type      rsp_data,
   output logic                   full
);

   logic              out_valid_ff, out_valid_in;
   wbps_pkg::rsp_type out_data_ff, out_data_in;
   logic              skid_valid_ff, skid_valid_in;
   wbps_pkg::rsp_type skid_data_ff, skid_data_in;
   logic              pop;

   assign pop = out_valid_ff && !rsp_stall;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         // No push can arrive while the skid entry is occupied.
         if (pop) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (out_valid_ff && !pop) begin
         if (push) begin
            skid_valid_in = 1'b1;
            skid_data_in  = push_data;
         end
      end else begin
         out_valid_in = push;
         if (push) begin
            out_data_in = push_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;
   assign full      = skid_valid_ff;

endmodule
`default_nettype wire

// ===== src/wildcard_byte_pattern_scanner.sv =====
// Top level of the wildcard byte pattern scanner: registers, cell row, result buffer.
// Depends on wbps_pkg, wbps_cell, wbps_out_buf and wildcard_byte_pattern_scanner_assert.svh.
//
//   Channel | Direction | Handshake           | Beat contents
//   --------+-----------+---------------------+-------------------------------------
//   req     | in        | req_valid/req_stall | data_byte, last_byte
//   rsp     | out       | rsp_valid/rsp_stall | found, match_address
//   csr     | in        | csr_valid/csr_ready | csr_index, csr_data (one register)
//
// One byte is accepted per clock cycle while req_stall is low; the cell row compares every
// window position in parallel, and the compare and address add are combinational.
// A result beat appears on rsp in the cycle after the byte that caused it, or later while
// rsp is stalled and earlier results still wait ahead of it.
// Reset is synchronous and active high; it clears all registers but the result buffer's data, and the window.
// req_stall rises only when both the output register and its skid entry hold results.
`default_nettype none
module wildcard_byte_pattern_scanner (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire wbps_pkg::req_type                 req_data,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output wbps_pkg::rsp_type                      rsp_data,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [wbps_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [wbps_pkg::CSR_DATA_W-1:0]   csr_data
);

   `include "wildcard_byte_pattern_scanner_assert.svh"

   // Configuration registers. The user must change them only while the scanner is idle; not enforced.
   logic [63:0]                     pattern_low_ff;
   logic [63:0]                     pattern_high_ff;
   logic [15:0]                     wildcard_mask_ff;
   logic [wbps_pkg::LEN_W-1:0]      pattern_length_ff;
   logic [wbps_pkg::ADDR_W-1:0]     region_base_ff;

   // Scan state that is not held in the cells.
   logic [wbps_pkg::COUNT_WIDTH-1:0] bytes_seen_ff, bytes_seen_in;
   logic                             matched_ff, matched_in;

   logic                                     accept;
   logic                                     buf_full;
   logic [wbps_pkg::COUNT_WIDTH-1:0]         count_next;
   logic [wbps_pkg::COUNT_WIDTH-1:0]         match_offset;
   wbps_pkg::lane_cfg_type                   lane_cfg [wbps_pkg::MAX_PATTERN_LEN];
   logic [wbps_pkg::MAX_PATTERN_LEN-1:0]     lane_ok_vec;
   logic [7:0]                               cell_byte [wbps_pkg::NUM_CELLS];
   logic                                     length_usable;
   logic                                     hit;
   logic                                     result_push;
   wbps_pkg::rsp_type                        result;

   // The csr port never pushes back.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_low_ff    <= '0;
         pattern_high_ff   <= '0;
         wildcard_mask_ff  <= '0;
         pattern_length_ff <= '0;
         region_base_ff    <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            wbps_pkg::CSR_PATTERN_LOW: begin
               pattern_low_ff <= csr_data;
            end
            wbps_pkg::CSR_PATTERN_HIGH: begin
               pattern_high_ff <= csr_data;
            end
            wbps_pkg::CSR_WILDCARD: begin
               wildcard_mask_ff <= csr_data[15:0];
            end
            wbps_pkg::CSR_LENGTH: begin
               pattern_length_ff <= csr_data[wbps_pkg::LEN_W-1:0];
            end
            wbps_pkg::CSR_BASE: begin
               region_base_ff <= csr_data[wbps_pkg::ADDR_W-1:0];
            end
            default: begin
               // Writes to unused indexes are dropped.
            end
         endcase
      end
   end

   assign accept = req_valid && !req_stall;

   // Window position p holds the byte that arrived p beats ago (position 0 is the
   // incoming byte). With the pattern right-aligned on the newest byte, position p
   // is compared against pattern byte length-1-p, and only positions below length
   // take part in the match.
   for (genvar p = 0; p < wbps_pkg::MAX_PATTERN_LEN; p++) begin : g_lane
      logic [wbps_pkg::LEN_W-1:0] pat_index;
      assign pat_index = pattern_length_ff - wbps_pkg::LEN_W'(1)
                       - wbps_pkg::LEN_W'(p);
      assign lane_cfg[p].in_use  = 32'(pattern_length_ff) > 32'(p);
      assign lane_cfg[p].wild    = wbps_pkg::pattern_wild(wildcard_mask_ff, pat_index);
      assign lane_cfg[p].pattern = wbps_pkg::pattern_byte(pattern_low_ff, pattern_high_ff,
                                                          pat_index);
   end

   assign lane_ok_vec[0] = wbps_pkg::lane_ok(lane_cfg[0], req_data.data_byte);

   // The cell row: each cell takes its neighbor's byte on every accepted beat that
   // does not end the region, and is cleared by the beat that does.
   for (genvar c = 0; c < wbps_pkg::NUM_CELLS; c++) begin : g_cell
      logic [7:0] shift_byte;
      if (c == 0) begin : g_head
         assign shift_byte = req_data.data_byte;
      end else begin : g_body
         assign shift_byte = cell_byte[c-1];
      end
      wbps_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .shift_en  (accept && !req_data.last_byte),
         .clear     (accept && req_data.last_byte),
         .prev_byte (shift_byte),
         .lane      (lane_cfg[c+1]),
         .byte_out  (cell_byte[c]),
         .ok        (lane_ok_vec[c+1])
      );
   end

   // Byte count including the incoming byte, saturating at its all-ones value.
   assign count_next = (bytes_seen_ff == '1) ? bytes_seen_ff
                                             : bytes_seen_ff + wbps_pkg::COUNT_WIDTH'(1);

   assign length_usable = (pattern_length_ff != '0)
                       && (32'(pattern_length_ff) <= 32'(wbps_pkg::MAX_PATTERN_LEN));

   // A match needs a usable pattern, a nonzero base, enough bytes in the region and no
   // earlier match in the same region.
   assign hit = accept && !matched_ff && (region_base_ff != '0) && length_usable
             && (count_next >= wbps_pkg::COUNT_WIDTH'(pattern_length_ff))
             && (&lane_ok_vec);

   assign match_offset = count_next - wbps_pkg::COUNT_WIDTH'(pattern_length_ff);

   // At most one result per beat: a match, or not-found on the last byte of a region
   // that never matched.
   always_comb begin
      result.found         = 1'b0;
      result.match_address = '0;
      if (hit) begin
         result.found         = 1'b1;
         result.match_address = region_base_ff + wbps_pkg::ADDR_W'(match_offset);
      end
   end

   assign result_push = hit || (accept && req_data.last_byte && !matched_ff);

   always_comb begin
      bytes_seen_in = bytes_seen_ff;
      matched_in    = matched_ff;
      if (accept) begin
         if (req_data.last_byte) begin
            bytes_seen_in = '0;
            matched_in    = 1'b0;
         end else begin
            bytes_seen_in = count_next;
            matched_in    = matched_ff || hit;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_seen_ff <= '0;
         matched_ff    <= 1'b0;
      end else begin
         bytes_seen_ff <= bytes_seen_in;
         matched_ff    <= matched_in;
      end
   end

   wbps_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (result_push),
      .push_data (result),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .full      (buf_full)
   );

   assign req_stall = buf_full;

   // The skid entry only fills behind a waiting output beat.
   `WBPS_ASSERT_IMPLIES(a_stall_needs_output, req_stall, rsp_valid)
   // A not-found beat always carries a zero address.
   `WBPS_ASSERT_IMPLIES(a_notfound_zero_addr, rsp_valid && !rsp_data.found,
                        rsp_data.match_address == '0)
   // The match flag is only ever set inside a region that has seen bytes.
   `WBPS_ASSERT_IMPLIES(a_matched_has_count, matched_ff, bytes_seen_ff != '0)
   // The last byte of a region starts the next one from a clean count and flag.
   `WBPS_ASSERT_NEXT(a_last_clears_scan, accept && req_data.last_byte,
                     bytes_seen_ff == '0 && !matched_ff)

endmodule
`default_nettype wire
